// File: hw/rtl/tae_pkg.sv
// ---------------------------------------------------------------------------
// tae_pkg
// Shared constants, codes and controller/datapath interface types for the
// timed ADSR envelope core.
// ---------------------------------------------------------------------------
package tae_pkg;

   localparam int LEN_BITS_DEFAULT  = 24;
   localparam int GAIN_FRAC_DEFAULT = 15;

   localparam int ELAPSED_W   = 32;
   localparam int GAIN_W      = 16;
   localparam int LEVEL_W     = 16;
   localparam int PHASE_W     = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int RSP_DATA_W  = ((GAIN_W + PHASE_W + 7) / 8) * 8;

   localparam logic [CSR_INDEX_W-1:0] REG_ATTACK_LEN    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DECAY_LEN     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SUSTAIN_LEN   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_RELEASE_LEN   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SUSTAIN_LEVEL = 3'd4;

   typedef enum logic [PHASE_W-1:0] {
      PH_ATTACK   = 3'd0,
      PH_DECAY    = 3'd1,
      PH_SUSTAIN  = 3'd2,
      PH_RELEASE  = 3'd3,
      PH_FINISHED = 3'd4
   } phase_type;

   typedef struct packed {
      logic accept;
      logic select;
      logic mul;
      logic div_load;
      logic div_step;
      logic out_load;
   } tae_cmd_type;

   typedef struct packed {
      logic div_done;
   } tae_stat_type;

endpackage

// File: hw/rtl/tae_regs.sv
// ---------------------------------------------------------------------------
// tae_regs
// Configuration register file: segment lengths and clamped sustain level.
// ---------------------------------------------------------------------------
module tae_regs #(
   parameter int LEN_BITS       = tae_pkg::LEN_BITS_DEFAULT,
   parameter int GAIN_FRAC_BITS = tae_pkg::GAIN_FRAC_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [tae_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [(LEN_BITS > tae_pkg::LEVEL_W ? LEN_BITS : tae_pkg::LEVEL_W)-1:0] csr_data,
   output logic [LEN_BITS-1:0]                    attack_len,
   output logic [LEN_BITS-1:0]                    decay_len,
   output logic [LEN_BITS-1:0]                    sustain_len,
   output logic [LEN_BITS-1:0]                    release_len,
   output logic [GAIN_FRAC_BITS:0]                level
);
   import tae_pkg::*;

   localparam int LVL_W = (GAIN_FRAC_BITS + 1 > LEVEL_W) ? GAIN_FRAC_BITS + 1 : LEVEL_W;
   localparam logic [LVL_W-1:0] FULL_X = LVL_W'(1) << GAIN_FRAC_BITS;
   localparam logic [LVL_W-1:0] HALF_X = LVL_W'(1) << (GAIN_FRAC_BITS - 1);

   logic [LEN_BITS-1:0] attack_ff, decay_ff, sustain_ff, release_ff;
   logic [LVL_W-1:0]    level_ff;
   logic                wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_ff  <= '0;
         decay_ff   <= '0;
         sustain_ff <= '0;
         release_ff <= '0;
         level_ff   <= HALF_X;
      end else if (wr) begin
         unique case (csr_index)
            REG_ATTACK_LEN:    attack_ff  <= csr_data[LEN_BITS-1:0];
            REG_DECAY_LEN:     decay_ff   <= csr_data[LEN_BITS-1:0];
            REG_SUSTAIN_LEN:   sustain_ff <= csr_data[LEN_BITS-1:0];
            REG_RELEASE_LEN:   release_ff <= csr_data[LEN_BITS-1:0];
            REG_SUSTAIN_LEVEL: level_ff   <= LVL_W'(csr_data[LEVEL_W-1:0]);
            default: ;
         endcase
      end
   end

   assign attack_len  = attack_ff;
   assign decay_len   = decay_ff;
   assign sustain_len = sustain_ff;
   assign release_len = release_ff;
   assign level       = (level_ff > FULL_X) ? FULL_X[GAIN_FRAC_BITS:0]
                                            : level_ff[GAIN_FRAC_BITS:0];

endmodule

// File: hw/rtl/tae_ctrl.sv
// ---------------------------------------------------------------------------
// tae_ctrl
// Sequencer: accept, segment select, multiply, divide, result hand-off.
// ---------------------------------------------------------------------------
module tae_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output tae_pkg::tae_cmd_type  cmd,
   input  tae_pkg::tae_stat_type stat
);
   import tae_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SEL  = 6'b000010,
      ST_MUL  = 6'b000100,
      ST_LOAD = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_FIN  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_SEL;
            end
         end
         ST_SEL: begin
            cmd.select = 1'b1;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_to_sel: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_SEL))
      else $error("accepted request did not start segment select");

   a_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over a pending response");

   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && stat.div_done) |=> (state_ff == ST_FIN))
      else $error("divider finished but sequencer did not advance");

endmodule

// File: hw/rtl/tae_dpath.sv
// ---------------------------------------------------------------------------
// tae_dpath
// Elapsed counter, segment select, ramp multiply and restoring divider.
// ---------------------------------------------------------------------------
module tae_dpath #(
   parameter int LEN_BITS       = tae_pkg::LEN_BITS_DEFAULT,
   parameter int GAIN_FRAC_BITS = tae_pkg::GAIN_FRAC_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tae_pkg::tae_cmd_type          cmd,
   output tae_pkg::tae_stat_type         stat,
   input  logic                          req_kind,
   input  logic [LEN_BITS-1:0]           req_advance,
   input  logic [LEN_BITS-1:0]           attack_len,
   input  logic [LEN_BITS-1:0]           decay_len,
   input  logic [LEN_BITS-1:0]           sustain_len,
   input  logic [LEN_BITS-1:0]           release_len,
   input  logic [GAIN_FRAC_BITS:0]       level,
   output logic [tae_pkg::GAIN_W-1:0]    rsp_gain,
   output logic [tae_pkg::PHASE_W-1:0]   rsp_phase
);
   import tae_pkg::*;

   localparam int GW    = GAIN_FRAC_BITS + 1;
   localparam int END_W = LEN_BITS + 2;
   localparam int CMP_W = (END_W > ELAPSED_W) ? END_W : ELAPSED_W;
   localparam int NUM_W = GW + LEN_BITS;
   localparam int OUT_W = (GW > GAIN_W) ? GW : GAIN_W;
   localparam int CNT_W = $clog2(GW);
   localparam logic [GW-1:0]    FULL      = GW'(1) << GAIN_FRAC_BITS;
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(GAIN_FRAC_BITS);

   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [ELAPSED_W:0]   sum;
   logic [END_W-1:0]     end_a_ff, end_d_ff, end_s_ff, end_r_ff;

   logic [CMP_W-1:0]     t_x;
   phase_type            phase_ff, phase_in;
   logic [GW-1:0]        span_ff, span_in, base_ff, base_in;
   logic [LEN_BITS-1:0]  pos_ff, pos_in, len_ff, len_in;
   logic                 sub_ff, sub_in;

   logic [NUM_W-1:0]     num_ff;
   logic [LEN_BITS-1:0]  rem_ff;
   logic [GW-1:0]        qd_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [LEN_BITS:0]    trial, diff;
   logic                 ge;

   logic [GW-1:0]        gain;
   logic [OUT_W-1:0]     gain_x;
   logic [GAIN_W-1:0]    rsp_gain_ff;
   logic [PHASE_W-1:0]   rsp_phase_ff;

   // clear on restart, else add the advance and saturate the elapsed count
   always_comb begin
      sum = {1'b0, elapsed_ff} + (ELAPSED_W + 1)'(req_advance);
      if (req_kind)     elapsed_in = '0;
      else if (sum[ELAPSED_W]) elapsed_in = '1;
      else              elapsed_in = sum[ELAPSED_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
      end else if (cmd.accept) begin
         elapsed_ff <= elapsed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         end_a_ff <= END_W'(attack_len);
         end_d_ff <= END_W'(attack_len) + END_W'(decay_len);
         end_s_ff <= END_W'(attack_len) + END_W'(decay_len) + END_W'(sustain_len);
         end_r_ff <= END_W'(attack_len) + END_W'(decay_len) + END_W'(sustain_len)
                     + END_W'(release_len);
      end
   end

   always_comb begin
      t_x      = CMP_W'(elapsed_ff);
      phase_in = PH_FINISHED;
      span_in  = '0;
      pos_in   = '0;
      len_in   = LEN_BITS'(1);
      base_in  = '0;
      sub_in   = 1'b1;
      if (t_x < CMP_W'(end_a_ff)) begin
         phase_in = PH_ATTACK;
         span_in  = FULL;
         pos_in   = t_x[LEN_BITS-1:0];
         len_in   = attack_len;
         sub_in   = 1'b0;
      end else if (t_x < CMP_W'(end_d_ff)) begin
         phase_in = PH_DECAY;
         span_in  = FULL - level;
         pos_in   = LEN_BITS'(t_x - CMP_W'(end_a_ff));
         len_in   = decay_len;
         base_in  = FULL;
      end else if (t_x < CMP_W'(end_s_ff)) begin
         phase_in = PH_SUSTAIN;
         base_in  = level;
      end else if (t_x < CMP_W'(end_r_ff)) begin
         phase_in = PH_RELEASE;
         span_in  = level;
         pos_in   = LEN_BITS'(t_x - CMP_W'(end_s_ff));
         len_in   = release_len;
         base_in  = level;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.select) begin
         phase_ff <= phase_in;
         span_ff  <= span_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         base_ff  <= base_in;
         sub_ff   <= sub_in;
      end
      if (cmd.mul) begin
         num_ff <= NUM_W'(span_ff) * NUM_W'(pos_ff);
      end
   end

   // one quotient bit per cycle
   assign trial = {rem_ff, qd_ff[GW-1]};
   assign diff  = trial - {1'b0, len_ff};
   assign ge    = (trial >= {1'b0, len_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.div_load) begin
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff <= num_ff[NUM_W-1:GW];
         qd_ff  <= num_ff[GW-1:0];
      end else if (cmd.div_step) begin
         rem_ff <= ge ? diff[LEN_BITS-1:0] : trial[LEN_BITS-1:0];
         qd_ff  <= {qd_ff[GW-2:0], ge};
      end
   end

   assign stat.div_done = (cnt_ff == LAST_STEP);

   assign gain   = sub_ff ? (base_ff - qd_ff) : qd_ff;
   assign gain_x = OUT_W'(gain);

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_gain_ff  <= gain_x[GAIN_W-1:0];
         rsp_phase_ff <= phase_ff;
      end
   end

   assign rsp_gain  = rsp_gain_ff;
   assign rsp_phase = rsp_phase_ff;

   a_pos_in_segment: assert property (@(posedge clock) disable iff (reset)
      cmd.select |=> (pos_ff < len_ff))
      else $error("segment position not below segment length");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_load || cmd.div_step) |=> (rem_ff < len_ff))
      else $error("divider remainder out of range");

   a_elapsed_monotonic: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && !req_kind) |=> (elapsed_ff >= $past(elapsed_ff)))
      else $error("elapsed count wrapped");

endmodule

// File: hw/rtl/timed_adsr_envelope_core.sv
// ---------------------------------------------------------------------------
// timed_adsr_envelope_core
// Linear ADSR envelope over a saturating elapsed-sample count; one gain and
// phase per request.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tuser kind, tdata advance
//   rsp      out        rsp_tvalid/rsp_tready  tdata gain, phase
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// A request passes through accept, segment select, multiply, divider load,
// the restoring divide, one quotient bit per cycle, and result hand-off;
// the next request is taken only after the result is handed off.
// Synchronous reset clears the elapsed count, lengths and state; the
// sustain level resets to half scale.
// A stalled response holds the finished result; the next request is taken
// while it waits.
// ---------------------------------------------------------------------------
module timed_adsr_envelope_core #(
   parameter int LEN_BITS       = tae_pkg::LEN_BITS_DEFAULT,
   parameter int GAIN_FRAC_BITS = tae_pkg::GAIN_FRAC_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((LEN_BITS + 7) / 8) * 8-1:0]  req_tdata,  // advance
   input  logic                                 req_tuser,  // kind
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [tae_pkg::RSP_DATA_W-1:0]       rsp_tdata,  // gain, phase
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tae_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [(LEN_BITS > tae_pkg::LEVEL_W ? LEN_BITS : tae_pkg::LEVEL_W)-1:0] csr_data
);
   import tae_pkg::*;

   localparam int PAD_W = RSP_DATA_W - GAIN_W - PHASE_W;

   tae_cmd_type               cmd;
   tae_stat_type              stat;
   logic [LEN_BITS-1:0]       attack_len, decay_len, sustain_len, release_len;
   logic [GAIN_FRAC_BITS:0]   level;
   logic [GAIN_W-1:0]         gain;
   logic [PHASE_W-1:0]        phase;

   tae_regs #(
      .LEN_BITS       (LEN_BITS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .attack_len  (attack_len),
      .decay_len   (decay_len),
      .sustain_len (sustain_len),
      .release_len (release_len),
      .level       (level)
   );

   tae_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   tae_dpath #(
      .LEN_BITS       (LEN_BITS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_kind    (req_tuser),
      .req_advance (req_tdata[LEN_BITS-1:0]),
      .attack_len  (attack_len),
      .decay_len   (decay_len),
      .sustain_len (sustain_len),
      .release_len (release_len),
      .level       (level),
      .rsp_gain    (gain),
      .rsp_phase   (phase)
   );

   assign rsp_tdata = {{PAD_W{1'b0}}, phase, gain};

endmodule

// File: tb/sv/timed_adsr_envelope_core_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// timed_adsr_envelope_core_test
// Drives advance and restart requests into the envelope core under several
// register settings and idling patterns, predicts each gain and phase from a
// model of the elapsed count and the four envelope segments, and compares every
// response in order against the predicted envelope points.
// ---------------------------------------------------------------------------
module timed_adsr_envelope_core_test;
   import tae_pkg::*;

   localparam int  REQ_DATA_W  = ((LEN_BITS_DEFAULT + 7) / 8) * 8;
   localparam int  CSR_DATA_W  = LEN_BITS_DEFAULT > LEVEL_W ? LEN_BITS_DEFAULT : LEVEL_W;
   localparam int  CYCLE_LIMIT = 600000;
   localparam int  REPORT_CAP  = 40;
   localparam logic [LEN_BITS_DEFAULT-1:0] LEN_MAX = '1;

   class envelope_scoreboard;
      typedef struct {
         logic [GAIN_W-1:0] gain;
         phase_type         phase;
      } envelope_point;

      localparam longint unsigned FULL_SCALE = 64'd1 << GAIN_FRAC_DEFAULT;

      logic [LEN_BITS_DEFAULT-1:0] attack_len;
      logic [LEN_BITS_DEFAULT-1:0] decay_len;
      logic [LEN_BITS_DEFAULT-1:0] sustain_len;
      logic [LEN_BITS_DEFAULT-1:0] release_len;
      logic [LEVEL_W-1:0]          sustain_level;
      logic [ELAPSED_W-1:0]        elapsed;
      envelope_point               expected_points[$];
      int                          errors;

      function new();
         attack_len    = '0;
         decay_len     = '0;
         sustain_len   = '0;
         release_len   = '0;
         sustain_level = LEVEL_W'(FULL_SCALE / 2);
         elapsed       = '0;
         errors        = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            REG_ATTACK_LEN:    attack_len    = data[LEN_BITS_DEFAULT-1:0];
            REG_DECAY_LEN:     decay_len     = data[LEN_BITS_DEFAULT-1:0];
            REG_SUSTAIN_LEN:   sustain_len   = data[LEN_BITS_DEFAULT-1:0];
            REG_RELEASE_LEN:   release_len   = data[LEN_BITS_DEFAULT-1:0];
            REG_SUSTAIN_LEVEL: sustain_level = data[LEVEL_W-1:0];
            default: ;
         endcase
      endfunction

      function longint unsigned total_length();
         return longint'(attack_len) + decay_len + sustain_len + release_len;
      endfunction

      // distance to the next segment end past the current count, 0 when finished
      function longint unsigned to_boundary();
         longint unsigned ends[4];
         ends[0] = attack_len;
         ends[1] = ends[0] + decay_len;
         ends[2] = ends[1] + sustain_len;
         ends[3] = ends[2] + release_len;
         foreach (ends[i])
            if (ends[i] > elapsed) return ends[i] - elapsed;
         return 0;
      endfunction

      function void note_request(logic kind, logic [LEN_BITS_DEFAULT-1:0] adv);
         logic [ELAPSED_W:0] sum;
         longint unsigned    t, end_a, end_d, end_s, end_r, lvl;
         envelope_point      point;
         if (kind) begin
            elapsed = '0;
         end else begin
            sum     = {1'b0, elapsed} + adv;
            elapsed = sum[ELAPSED_W] ? '1 : sum[ELAPSED_W-1:0];
         end
         lvl   = sustain_level > FULL_SCALE ? FULL_SCALE : sustain_level;
         t     = elapsed;
         end_a = attack_len;
         end_d = end_a + decay_len;
         end_s = end_d + sustain_len;
         end_r = end_s + release_len;
         if (t < end_a) begin
            point.phase = PH_ATTACK;
            point.gain  = GAIN_W'(FULL_SCALE * t / attack_len);
         end else if (t < end_d) begin
            point.phase = PH_DECAY;
            point.gain  = GAIN_W'(FULL_SCALE - (FULL_SCALE - lvl) * (t - end_a) / decay_len);
         end else if (t < end_s) begin
            point.phase = PH_SUSTAIN;
            point.gain  = GAIN_W'(lvl);
         end else if (t < end_r) begin
            point.phase = PH_RELEASE;
            point.gain  = GAIN_W'(lvl - lvl * (t - end_s) / release_len);
         end else begin
            point.phase = PH_FINISHED;
            point.gain  = '0;
         end
         expected_points.push_back(point);
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] data);
         envelope_point     point;
         logic [GAIN_W-1:0]  gain;
         logic [PHASE_W-1:0] phase;
         gain  = data[GAIN_W-1:0];
         phase = data[GAIN_W +: PHASE_W];
         if (expected_points.size() == 0) begin
            if (errors < REPORT_CAP)
               $display("%0t: unexpected response, actual gain %0d phase %0d",
                        $time, gain, phase);
            errors++;
            return;
         end
         point = expected_points.pop_front();
         if (gain !== point.gain) begin
            if (errors < REPORT_CAP)
               $display("%0t: gain mismatch, expected %0d actual %0d",
                        $time, point.gain, gain);
            errors++;
         end
         if (phase !== point.phase) begin
            if (errors < REPORT_CAP)
               $display("%0t: phase mismatch, expected %0d actual %0d",
                        $time, point.phase, phase);
            errors++;
         end
      endfunction

      function void close_out();
         if (expected_points.size() != 0) begin
            $display("%0t: %0d expected responses never arrived",
                     $time, expected_points.size());
            errors += expected_points.size();
         end
      endfunction
   endclass

   logic                                clock;
   logic                                reset;
   logic                                req_tvalid;
   logic                                req_tready;
   logic [REQ_DATA_W-1:0]               req_tdata;   // advance
   logic                                req_tuser;   // kind
   logic                                rsp_tvalid;
   logic                                rsp_tready;
   logic [RSP_DATA_W-1:0]               rsp_tdata;   // gain, phase
   logic                                csr_valid;
   logic                                csr_ready;
   logic [CSR_INDEX_W-1:0]              csr_index;
   logic [CSR_DATA_W-1:0]               csr_data;

   envelope_scoreboard envelope_board;
   int                 req_idle_pct;
   int                 rsp_stall_pct;
   int                 cycle_count;

   timed_adsr_envelope_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= $urandom_range(99) >= rsp_stall_pct;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) envelope_board.check_response(rsp_tdata);
   end

   task automatic set_idling(int mode);
      case (mode % 4)
         0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin req_idle_pct = 47; rsp_stall_pct = 0;  end
         2: begin req_idle_pct = 0;  rsp_stall_pct = 47; end
         default: begin req_idle_pct = 23; rsp_stall_pct = 23; end
      endcase
   endtask

   task automatic send_request(logic kind, logic [LEN_BITS_DEFAULT-1:0] adv);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= REQ_DATA_W'(adv);
      do @(posedge clock); while (!req_tready);
      envelope_board.note_request(kind, adv);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      envelope_board.write_register(index, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (envelope_board.expected_points.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(logic [CSR_DATA_W-1:0] atk, logic [CSR_DATA_W-1:0] dec,
                            logic [CSR_DATA_W-1:0] sus, logic [CSR_DATA_W-1:0] rel,
                            logic [CSR_DATA_W-1:0] lvl);
      wait_idle();
      write_csr(REG_ATTACK_LEN, atk);
      write_csr(REG_DECAY_LEN, dec);
      write_csr(REG_SUSTAIN_LEN, sus);
      write_csr(REG_RELEASE_LEN, rel);
      write_csr(REG_SUSTAIN_LEVEL, lvl);
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_length();
      case ($urandom_range(9))
         0, 1:       return '0;
         2, 3, 4, 5: return CSR_DATA_W'($urandom_range(1, 40));
         6, 7:       return CSR_DATA_W'($urandom_range(41, 5000));
         8:          return CSR_DATA_W'($urandom_range(LEN_MAX));
         default:    return CSR_DATA_W'(LEN_MAX);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_level();
      logic [CSR_DATA_W-1:0] data;
      data = CSR_DATA_W'($urandom);
      case ($urandom_range(5))
         0:       data[LEVEL_W-1:0] = '0;
         1:       data[LEVEL_W-1:0] = LEVEL_W'(32768);
         2:       data[LEVEL_W-1:0] = LEVEL_W'($urandom_range(32769, 65535));
         default: data[LEVEL_W-1:0] = LEVEL_W'($urandom_range(32768));
      endcase
      return data;
   endfunction

   task automatic random_config();
      logic [CSR_INDEX_W-1:0] spare;
      configure(pick_length(), pick_length(), pick_length(), pick_length(), pick_level());
      if ($urandom_range(2) == 0) begin
         spare = CSR_INDEX_W'($urandom_range(REG_SUSTAIN_LEVEL + 1, (1 << CSR_INDEX_W) - 1));
         write_csr(spare, CSR_DATA_W'($urandom));
      end
   endtask

   task automatic random_requests(int count);
      longint unsigned             total, span;
      logic                        kind;
      logic [LEN_BITS_DEFAULT-1:0] adv;
      int                          pick;
      send_request(1'b1, LEN_BITS_DEFAULT'($urandom));
      for (int i = 1; i < count; i++) begin
         total = envelope_board.total_length();
         kind  = 1'b0;
         pick  = $urandom_range(99);
         if (envelope_board.elapsed >= total && $urandom_range(1) == 0) pick = 0;
         if (pick < 8) begin
            kind = 1'b1;
            adv  = LEN_BITS_DEFAULT'($urandom);
         end else if (pick < 35) begin
            span = envelope_board.to_boundary();
            if (span > LEN_MAX) span = LEN_MAX;
            if (span > 0 && $urandom_range(1) == 0) span = span - 1;
            adv = LEN_BITS_DEFAULT'(span);
         end else if (pick < 75) begin
            span = total / 6 + 2;
            if (span > LEN_MAX) span = LEN_MAX;
            adv = LEN_BITS_DEFAULT'($urandom_range(0, 32'(span)));
         end else if (pick < 85) begin
            adv = LEN_BITS_DEFAULT'($urandom_range(1));
         end else begin
            adv = LEN_BITS_DEFAULT'($urandom);
         end
         send_request(kind, adv);
      end
   endtask

   initial begin
      envelope_board = new();
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tuser   = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      cycle_count = 0;
      set_idling(0);
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: every length zero, so the envelope is already finished
      send_request(1'b1, '0);
      send_request(1'b0, LEN_MAX);

      // short segments with the sustain level still at its reset value
      wait_idle();
      write_csr(REG_ATTACK_LEN, 10);
      write_csr(REG_DECAY_LEN, 10);
      write_csr(REG_SUSTAIN_LEN, 10);
      write_csr(REG_RELEASE_LEN, 10);
      for (int i = REG_SUSTAIN_LEVEL + 1; i < (1 << CSR_INDEX_W); i++)
         write_csr(CSR_INDEX_W'(i), CSR_DATA_W'($urandom));
      send_request(1'b1, LEN_MAX);
      send_request(1'b0, 5);
      send_request(1'b0, 5);
      send_request(1'b0, 9);
      send_request(1'b0, 1);
      send_request(1'b0, 10);
      send_request(1'b0, 9);
      send_request(1'b0, 1);

      // skipped attack and decay, sustain level above full scale
      configure(0, 0, 3, LEN_MAX, CSR_DATA_W'(16'hFFFF));
      send_request(1'b1, '0);
      send_request(1'b0, 3);
      send_request(1'b0, LEN_BITS_DEFAULT'(24'h800000));
      send_request(1'b1, LEN_MAX);

      // longest segments, zero sustain level
      configure(LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX, 0);
      send_request(1'b1, '0);
      send_request(1'b0, LEN_MAX - 1);
      send_request(1'b0, 1);
      send_request(1'b0, LEN_MAX);

      // no attack, no sustain, full-scale level
      configure(0, 7, 0, 5, CSR_DATA_W'(32768));
      send_request(1'b1, '0);
      send_request(1'b0, 7);
      send_request(1'b0, 4);
      send_request(1'b0, 1);

      for (int p = 0; p < 12; p++) begin
         wait_idle();
         set_idling(p);
         if (p == 5) begin
            // advance the count in long steps with long segments in place
            configure(CSR_DATA_W'($urandom_range(24'h800000, LEN_MAX)), LEN_MAX,
                      LEN_MAX, LEN_MAX, pick_level());
            send_request(1'b1, '0);
            for (int i = 0; i < 270; i++)
               send_request(1'b0, $urandom_range(3) == 0 ?
                            LEN_BITS_DEFAULT'($urandom) : LEN_MAX);
            send_request(1'b0, '0);
         end else begin
            random_config();
            random_requests(60);
         end
      end

      wait_idle();
      repeat (30) @(posedge clock);
      envelope_board.close_out();
      if (envelope_board.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
